// ===== design/nisqrt_pkg.sv =====
// ----------------------------------------------------------------------------
// nisqrt_pkg
// Shared types and constants for the nearest integer square root block.
// ----------------------------------------------------------------------------
package nisqrt_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned ROOT_OUT_W      = 17;
  localparam int unsigned OUT_TDATA_W     = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ROUND
  } state_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture a new value, clear root and remainder
    logic step;      // resolve one root bit
    logic out_load;  // round and write the output register
  } cmd_t;

endpackage

// ===== design/nisqrt_dp.sv =====
// ----------------------------------------------------------------------------
// nisqrt_dp
// Digit-by-digit square root datapath: one root bit per step, then rounding
// to nearest and the output register.
// ----------------------------------------------------------------------------
module nisqrt_dp #(
  parameter int unsigned VALUE_WIDTH = nisqrt_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned IN_W        = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  nisqrt_pkg::cmd_t                   cmd_i,
  input  logic [IN_W-1:0]                    value_i,
  output logic [nisqrt_pkg::ROOT_OUT_W-1:0]  root_o,
  output logic                               exact_o
);

  localparam int unsigned RB    = (VALUE_WIDTH + 1) / 2;
  localparam int unsigned RW    = RB + 1;
  localparam int unsigned EXT_W = (RW > nisqrt_pkg::ROOT_OUT_W) ? RW : nisqrt_pkg::ROOT_OUT_W;

  logic [2*RB-1:0]                   val_q, val_d, val_ext;
  logic [RB:0]                       rem_q, rem_d;
  logic [RB-1:0]                     root_q, root_d;
  logic [RB+1:0]                     rem_sh, trial, diff;
  logic                              ge;
  logic [RW-1:0]                     rnd_root;
  logic [EXT_W-1:0]                  root_ext;
  logic [nisqrt_pkg::ROOT_OUT_W-1:0] root_out_q;
  logic                              exact_q;

  always_comb begin
    val_ext                  = '0;
    val_ext[VALUE_WIDTH-1:0] = value_i[VALUE_WIDTH-1:0];
  end

  // Bring down the next two value bits and try (root << 2) | 1
  assign rem_sh = {rem_q[RB-1:0], val_q[2*RB-1 -: 2]};
  assign trial  = {root_q, 2'b01};
  assign ge     = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  always_comb begin
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (cmd_i.load) begin
      val_d  = val_ext;
      rem_d  = '0;
      root_d = '0;
    end else if (cmd_i.step) begin
      val_d  = val_q << 2;
      rem_d  = ge ? diff[RB:0] : rem_sh[RB:0];
      root_d = RB'({root_q, ge});
    end
  end

  // Remainder above the floor root means the next root is nearer
  assign rnd_root = (rem_q > {1'b0, root_q}) ? ({1'b0, root_q} + RW'(1)) : {1'b0, root_q};

  always_comb begin
    root_ext         = '0;
    root_ext[RW-1:0] = rnd_root;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      val_q  <= val_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      root_out_q <= root_ext[nisqrt_pkg::ROOT_OUT_W-1:0];
      exact_q    <= (rem_q == '0);
    end
  end

  assign root_o  = root_out_q;
  assign exact_o = exact_q;

`ifndef SYNTHESIS
  // Remainder never exceeds twice the partial root
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_q <= {root_q, 1'b0})
    else $error("remainder exceeds 2*root");
`endif

endmodule

// ===== design/nisqrt_ctrl.sv =====
// ----------------------------------------------------------------------------
// nisqrt_ctrl
// Sequencer: takes a transaction, runs one step per root bit, rounds, and
// hands the result to the output register.
// ----------------------------------------------------------------------------
module nisqrt_ctrl #(
  parameter int unsigned VALUE_WIDTH = nisqrt_pkg::VALUE_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output nisqrt_pkg::cmd_t cmd_o
);

  localparam int unsigned RB    = (VALUE_WIDTH + 1) / 2;
  localparam int unsigned CNT_W = $clog2(RB + 1);

  nisqrt_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               out_vld_q, out_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= nisqrt_pkg::ST_IDLE;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      nisqrt_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = CNT_W'(RB - 1);
          state_d    = nisqrt_pkg::ST_RUN;
        end
      end
      nisqrt_pkg::ST_RUN: begin
        cmd_o.step = 1'b1;
        if (cnt_q == '0) begin
          state_d = nisqrt_pkg::ST_ROUND;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      nisqrt_pkg::ST_ROUND: begin
        // Hold until the output register is free or being drained
        if (!out_vld_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = nisqrt_pkg::ST_IDLE;
        end
      end
      default: state_d = nisqrt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  assign out_valid_o = out_vld_q;

`ifndef SYNTHESIS
  a_load_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == nisqrt_pkg::ST_RUN) && (cnt_q == CNT_W'(RB - 1)))
    else $error("accepted transaction did not start the bit loop");

  a_out_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_vld_q)
    else $error("result written but not presented");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_vld_q || out_ready_i))
    else $error("output register overwritten before taken");
`endif

endmodule

// ===== design/nearest_integer_square_root_top.sv =====
// Sequencing: an accepted value is resolved one root bit per cycle, then rounded to
//   nearest and written to the output register, which raises m_axis_tvalid_o.
// Overlap: a new value is taken only while idle, not while one is being resolved; the next value is
//   taken while the previous result waits in the output register.
// Reset: rst_ni is asynchronous, active low; it returns the sequencer to idle and
//   drops m_axis_tvalid_o.
// ----------------------------------------------------------------------------
// nearest_integer_square_root_top
// Square root rounded to nearest, with an exact-square flag.
// ----------------------------------------------------------------------------
module nearest_integer_square_root_top #(
  parameter int unsigned VALUE_WIDTH = nisqrt_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned IN_W        = ((VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [IN_W-1:0]                    s_axis_tdata_i,  // value
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [nisqrt_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o   // root[16:0], exact, zero pad
);

  nisqrt_pkg::cmd_t                  cmd;
  logic [nisqrt_pkg::ROOT_OUT_W-1:0] root;
  logic                              exact;

  nisqrt_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .cmd_o       (cmd)
  );

  nisqrt_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .IN_W        (IN_W)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .value_i (s_axis_tdata_i),
    .root_o  (root),
    .exact_o (exact)
  );

  assign m_axis_tdata_o = {
    {(nisqrt_pkg::OUT_TDATA_W - nisqrt_pkg::ROOT_OUT_W - 1){1'b0}}, exact, root};

endmodule
